// File: src/ccq_pkg.sv
package ccq_pkg;

    // queue geometry
    localparam int QUEUE_DEPTH = 8;
    localparam int IDX_W       = $clog2(QUEUE_DEPTH);
    localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);

    // field widths
    localparam int TYPE_W  = 3;
    localparam int PAY_W   = 64;
    localparam int EXT_W   = 8;
    localparam int TIME_W  = 32;
    localparam int STAT_W  = 3;
    localparam int OCNT_W  = 4;

    localparam logic [TIME_W-1:0] EXPIRY_RESET = 32'd10000;
    localparam logic [TYPE_W-1:0] TYPE_TOGGLE  = 3'd4;

    // action codes
    localparam logic ACT_ENQUEUE = 1'b0;
    localparam logic ACT_POLL    = 1'b1;

    // status codes
    localparam logic [STAT_W-1:0] ST_APPENDED  = 3'd0;
    localparam logic [STAT_W-1:0] ST_COALESCED = 3'd1;
    localparam logic [STAT_W-1:0] ST_DROPPED   = 3'd2;
    localparam logic [STAT_W-1:0] ST_DELIVERED = 3'd3;
    localparam logic [STAT_W-1:0] ST_EMPTY     = 3'd4;

    // one queued command
    typedef struct packed {
        logic [TYPE_W-1:0] cmd_type;
        logic [PAY_W-1:0]  payload;
        logic [EXT_W-1:0]  payload_ext;
        logic [TIME_W-1:0] stamp;
    } t_entry;

    localparam int ENTRY_W = $bits(t_entry);

    // one input item as held during its walk
    typedef struct packed {
        logic              action;
        logic [TYPE_W-1:0] cmd_type;
        logic [PAY_W-1:0]  payload;
        logic [EXT_W-1:0]  payload_ext;
        logic [TIME_W-1:0] now_ms;
    } t_in_item;

    // one result item
    typedef struct packed {
        logic [STAT_W-1:0] status;
        logic [TYPE_W-1:0] out_type;
        logic [PAY_W-1:0]  out_payload;
        logic [EXT_W-1:0]  out_payload_ext;
        logic [OCNT_W-1:0] expired_count;
        logic [OCNT_W-1:0] occupancy;
    } t_result;

    // clamp a count to the four-bit result fields
    function automatic logic [OCNT_W-1:0] sat4(input logic [CNT_W-1:0] v);
        logic [31:0] w;
        w = 32'(v);
        return (w > 32'd15) ? 4'd15 : w[OCNT_W-1:0];
    endfunction

endpackage

// File: src/ccq_if.sv
interface ccq_in_if;
    import ccq_pkg::*;

    logic              valid;
    logic              ready;
    logic              action;
    logic [TYPE_W-1:0] cmd_type;
    logic [PAY_W-1:0]  payload;
    logic [EXT_W-1:0]  payload_ext;
    logic [TIME_W-1:0] now_ms;

    modport source (output valid, action, cmd_type, payload, payload_ext, now_ms,
                    input ready);
    modport sink   (input valid, action, cmd_type, payload, payload_ext, now_ms,
                    output ready);
endinterface

interface ccq_out_if;
    import ccq_pkg::*;

    logic              valid;
    logic              ready;
    logic [STAT_W-1:0] status;
    logic [TYPE_W-1:0] out_type;
    logic [PAY_W-1:0]  out_payload;
    logic [EXT_W-1:0]  out_payload_ext;
    logic [OCNT_W-1:0] expired_count;
    logic [OCNT_W-1:0] occupancy;

    modport source (output valid, status, out_type, out_payload, out_payload_ext,
                    expired_count, occupancy, input ready);
    modport sink   (input valid, status, out_type, out_payload, out_payload_ext,
                    expired_count, occupancy, output ready);
endinterface

// File: src/ccq_ram.sv
module ccq_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 8
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // write port, registered read port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// File: src/coalescing_command_queue_unit.sv
// Sequence from input transfer to result: a poll of an empty queue goes straight to emit;
//   an append or a drop goes through the append state; each entry walked adds a read
//   state and a check state. One item is in flight at a time and the input reopens
//   once the result is registered, so the block takes no new item until it is done.
// Reset (synchronous, active low): queue empty, head and tail at slot 0, expiry limit 10000.
//   Entry memory is not cleared; only written slots are ever read.
module coalescing_command_queue_unit (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    ccq_in_if.sink                 i_in,
    ccq_out_if.source              o_out,
    input  logic                   i_cfg_we,
    input  logic [ccq_pkg::TIME_W-1:0] i_cfg_wdata
);
    import ccq_pkg::*;

    typedef enum logic [4:0] {
        S_IDLE   = 5'b00001,
        S_RD     = 5'b00010,
        S_CHK    = 5'b00100,
        S_APPEND = 5'b01000,
        S_EMIT   = 5'b10000
    } t_state;

    t_state            r_state, n_state;
    logic [IDX_W-1:0]  r_head, n_head;
    logic [IDX_W-1:0]  r_tail, n_tail;
    logic [CNT_W-1:0]  r_count, n_count;
    logic [IDX_W-1:0]  r_ptr, n_ptr;
    logic [CNT_W-1:0]  r_i, n_i;
    logic [CNT_W-1:0]  r_exp, n_exp;
    logic [TIME_W-1:0] r_limit, n_limit;
    t_in_item          r_item, n_item;
    t_result           r_pend, n_pend;
    t_result           r_out, n_out;
    logic              r_out_valid, n_out_valid;

    logic              ram_we;
    logic [IDX_W-1:0]  ram_waddr;
    t_entry            ram_wdata;
    t_entry            ram_rdata;
    logic              in_xfer;
    logic [TIME_W-1:0] age;
    logic [CNT_W-1:0]  cnt_dec;

    function automatic logic [IDX_W-1:0] next_slot(input logic [IDX_W-1:0] s);
        return (s == IDX_W'(QUEUE_DEPTH - 1)) ? '0 : s + IDX_W'(1);
    endfunction

    ccq_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (QUEUE_DEPTH)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (r_ptr),
        .o_rdata (ram_rdata)
    );

    assign i_in.ready = (r_state == S_IDLE);
    assign in_xfer    = i_in.valid && i_in.ready;
    assign age        = r_item.now_ms - ram_rdata.stamp;
    assign cnt_dec    = r_count - CNT_W'(1);

    assign o_out.valid           = r_out_valid;
    assign o_out.status          = r_out.status;
    assign o_out.out_type        = r_out.out_type;
    assign o_out.out_payload     = r_out.out_payload;
    assign o_out.out_payload_ext = r_out.out_payload_ext;
    assign o_out.expired_count   = r_out.expired_count;
    assign o_out.occupancy       = r_out.occupancy;

    // sequencer: walk the queue, modify and write back
    always_comb begin
        n_state     = r_state;
        n_head      = r_head;
        n_tail      = r_tail;
        n_count     = r_count;
        n_ptr       = r_ptr;
        n_i         = r_i;
        n_exp       = r_exp;
        n_limit     = r_limit;
        n_item      = r_item;
        n_pend      = r_pend;
        n_out       = r_out;
        n_out_valid = r_out_valid;
        ram_we      = 1'b0;
        ram_waddr   = r_ptr;
        ram_wdata   = '{cmd_type: r_item.cmd_type, payload: r_item.payload,
                        payload_ext: r_item.payload_ext, stamp: r_item.now_ms};

        // drop the result once taken
        if (r_out_valid && o_out.ready) begin
            n_out_valid = 1'b0;
        end

        if (i_cfg_we) begin
            n_limit = i_cfg_wdata;
        end

        case (r_state)
            S_IDLE: begin
                if (in_xfer) begin
                    n_item = '{action: i_in.action, cmd_type: i_in.cmd_type,
                               payload: i_in.payload, payload_ext: i_in.payload_ext,
                               now_ms: i_in.now_ms};
                    n_pend = '0;
                    n_ptr  = r_head;
                    n_i    = '0;
                    n_exp  = '0;
                    if (i_in.action == ACT_POLL) begin
                        if (r_count == '0) begin
                            n_pend.status = ST_EMPTY;
                            n_state       = S_EMIT;
                        end else begin
                            n_state = S_RD;
                        end
                    end else if ((i_in.cmd_type < TYPE_TOGGLE) && (r_count != '0)) begin
                        n_state = S_RD;
                    end else begin
                        n_state = S_APPEND;
                    end
                end
            end
            S_RD: begin
                n_state = S_CHK;
            end
            S_CHK: begin
                if (r_item.action == ACT_POLL) begin
                    // pop the head, discard it if too old
                    n_head  = next_slot(r_head);
                    n_count = cnt_dec;
                    n_ptr   = next_slot(r_ptr);
                    if (age > r_limit) begin
                        n_exp = r_exp + CNT_W'(1);
                        if (cnt_dec == '0) begin
                            n_pend.status        = ST_EMPTY;
                            n_pend.expired_count = sat4(r_exp + CNT_W'(1));
                            n_state              = S_EMIT;
                        end else begin
                            n_state = S_RD;
                        end
                    end else begin
                        n_pend.status          = ST_DELIVERED;
                        n_pend.out_type        = ram_rdata.cmd_type;
                        n_pend.out_payload     = ram_rdata.payload;
                        n_pend.out_payload_ext = ram_rdata.payload_ext;
                        n_pend.expired_count   = sat4(r_exp);
                        n_state                = S_EMIT;
                    end
                end else if (ram_rdata.cmd_type == r_item.cmd_type) begin
                    // overwrite the match in place
                    ram_we        = 1'b1;
                    ram_waddr     = r_ptr;
                    n_pend.status = ST_COALESCED;
                    n_state       = S_EMIT;
                end else if ((r_i + CNT_W'(1)) == r_count) begin
                    n_state = S_APPEND;
                end else begin
                    n_i     = r_i + CNT_W'(1);
                    n_ptr   = next_slot(r_ptr);
                    n_state = S_RD;
                end
            end
            S_APPEND: begin
                if (r_count == CNT_W'(QUEUE_DEPTH)) begin
                    n_pend.status = ST_DROPPED;
                end else begin
                    ram_we        = 1'b1;
                    ram_waddr     = r_tail;
                    n_tail        = next_slot(r_tail);
                    n_count       = r_count + CNT_W'(1);
                    n_pend.status = ST_APPENDED;
                end
                n_state = S_EMIT;
            end
            S_EMIT: begin
                // hold until the output register is free
                if (!r_out_valid || o_out.ready) begin
                    n_out           = r_pend;
                    n_out.occupancy = sat4(r_count);
                    n_out_valid     = 1'b1;
                    n_state         = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_head      <= '0;
            r_tail      <= '0;
            r_count     <= '0;
            r_ptr       <= '0;
            r_i         <= '0;
            r_exp       <= '0;
            r_limit     <= EXPIRY_RESET;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_head      <= n_head;
            r_tail      <= n_tail;
            r_count     <= n_count;
            r_ptr       <= n_ptr;
            r_i         <= n_i;
            r_exp       <= n_exp;
            r_limit     <= n_limit;
            r_out_valid <= n_out_valid;
        end
    end

    // payload
    always_ff @(posedge i_clk) begin
        r_item <= n_item;
        r_pend <= n_pend;
        r_out  <= n_out;
    end

endmodule

// File: verif/testbench.sv
`timescale 1ns / 100ps

module testbench;
    import ccq_pkg::*;

    localparam int PHASES         = 6;
    localparam int PHASE_ITEMS    = 240;
    localparam int WALK_CYCLES    = 2 * QUEUE_DEPTH + 3;
    localparam int LIMIT_CYCLES   = 400000;
    localparam logic [PAY_W-1:0] PAY_ONES = {PAY_W{1'b1}};

    // one row of the directed table
    typedef struct {
        t_in_item cmd;
        bit       typed;
        t_result  want;
    } t_row;

    logic clk;
    logic rst_n;
    logic cfg_we;
    logic [TIME_W-1:0] cfg_wdata;

    ccq_in_if  in_if();
    ccq_out_if out_if();

    coalescing_command_queue_unit dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in        (in_if),
        .o_out       (out_if),
        .i_cfg_we    (cfg_we),
        .i_cfg_wdata (cfg_wdata)
    );

    // shadow queue state
    t_entry            slot_q [QUEUE_DEPTH];
    logic [IDX_W-1:0]  head_ptr;
    logic [IDX_W-1:0]  tail_ptr;
    int unsigned       fill;
    logic [TIME_W-1:0] max_age;
    logic [TIME_W-1:0] clock_ms;

    t_result expected_results[$];
    int      errors;
    int      cycle_count;
    int      n_enq, n_poll, n_settings;
    int      n_delivered, n_coalesced, n_dropped, n_expired;

    // free-running clock
    initial begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // run guard
    initial cycle_count = 0;
    always @(posedge clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= LIMIT_CYCLES) begin
            $display("testbench failed");
            $finish;
        end
    end

    function automatic logic [IDX_W-1:0] next_slot(input logic [IDX_W-1:0] s);
        return IDX_W'((int'(s) + 1) % QUEUE_DEPTH);
    endfunction

    function automatic logic [OCNT_W-1:0] clamp_count(input int unsigned v);
        return (v > 15) ? OCNT_W'(15) : OCNT_W'(v);
    endfunction

    // advance the shadow queue by one command and return its outcome
    function automatic t_result predict_step(input t_in_item cmd);
        t_result           r;
        logic [IDX_W-1:0]  s;
        logic [TIME_W-1:0] age;
        bit                hit;
        int unsigned       expired;
        r = '0;
        hit = 1'b0;
        expired = 0;
        if (cmd.action == ACT_ENQUEUE) begin
            // set-type commands overwrite the oldest queued entry of their type
            if (cmd.cmd_type < TYPE_TOGGLE) begin
                s = head_ptr;
                for (int i = 0; i < fill; i++) begin
                    if (!hit && slot_q[s].cmd_type == cmd.cmd_type) begin
                        slot_q[s].payload     = cmd.payload;
                        slot_q[s].payload_ext = cmd.payload_ext;
                        slot_q[s].stamp       = cmd.now_ms;
                        hit = 1'b1;
                    end
                    s = next_slot(s);
                end
            end
            if (hit) begin
                r.status = ST_COALESCED;
            end else if (fill >= QUEUE_DEPTH) begin
                r.status = ST_DROPPED;
            end else begin
                slot_q[tail_ptr] = {cmd.cmd_type, cmd.payload, cmd.payload_ext, cmd.now_ms};
                tail_ptr = next_slot(tail_ptr);
                fill++;
                r.status = ST_APPENDED;
            end
        end else begin
            // pop stale entries until a live one turns up
            r.status = ST_EMPTY;
            while (fill > 0 && r.status == ST_EMPTY) begin
                s = head_ptr;
                age = cmd.now_ms - slot_q[s].stamp;
                head_ptr = next_slot(head_ptr);
                fill--;
                if (age > max_age) begin
                    expired++;
                end else begin
                    r.status          = ST_DELIVERED;
                    r.out_type        = slot_q[s].cmd_type;
                    r.out_payload     = slot_q[s].payload;
                    r.out_payload_ext = slot_q[s].payload_ext;
                end
            end
            r.expired_count = clamp_count(expired);
        end
        r.occupancy = clamp_count(fill);
        return r;
    endfunction

    function automatic t_row mk_row(input logic act, input int ctype,
                                    input logic [PAY_W-1:0] pay, input int ext,
                                    input logic [TIME_W-1:0] now, input bit typed,
                                    input logic [STAT_W-1:0] st, input int otype,
                                    input logic [PAY_W-1:0] opay, input int oext,
                                    input int expd, input int occ);
        t_row row;
        row.cmd   = {act, TYPE_W'(ctype), pay, EXT_W'(ext), now};
        row.typed = typed;
        row.want  = {st, TYPE_W'(otype), opay, EXT_W'(oext), OCNT_W'(expd), OCNT_W'(occ)};
        return row;
    endfunction

    // random command; time moves so that ages straddle the expiry limit
    function automatic t_in_item make_random_item(input int enq_pct);
        t_in_item cmd;
        int       pick;
        cmd.action = ($urandom_range(0, 99) < enq_pct) ? ACT_ENQUEUE : ACT_POLL;
        if ($urandom_range(0, 4) == 0)
            cmd.cmd_type = TYPE_W'($urandom_range(0, 7));
        else
            cmd.cmd_type = TYPE_W'($urandom_range(0, 4));
        cmd.payload     = {$urandom, $urandom};
        cmd.payload_ext = EXT_W'($urandom);
        pick = $urandom_range(0, 99);
        if (pick >= 35) begin
            if (pick < 60)
                clock_ms = clock_ms + TIME_W'($urandom_range(1, 4));
            else if (pick < 80)
                clock_ms = clock_ms + max_age / TIME_W'($urandom_range(2, 8));
            else if (pick < 95 && fill != 0)
                clock_ms = slot_q[head_ptr].stamp + max_age
                           + TIME_W'($urandom_range(0, 2)) - TIME_W'(1);
            else
                clock_ms = $urandom;
        end
        cmd.now_ms = clock_ms;
        return cmd;
    endfunction

    // drive one command and hold it until the transfer
    task automatic send_cmd(input t_in_item cmd, input bit typed, input t_result want);
        t_result predicted;
        in_if.valid       <= 1'b1;
        in_if.action      <= cmd.action;
        in_if.cmd_type    <= cmd.cmd_type;
        in_if.payload     <= cmd.payload;
        in_if.payload_ext <= cmd.payload_ext;
        in_if.now_ms      <= cmd.now_ms;
        do @(posedge clk); while (in_if.ready !== 1'b1);
        predicted = predict_step(cmd);
        expected_results.push_back(typed ? want : predicted);
        if (cmd.action == ACT_ENQUEUE) n_enq++;
        else n_poll++;
        @(negedge clk);
    endtask

    // drop valid for a gap given by n, n at least one
    task automatic pause(input int n);
        in_if.valid <= 1'b0;
        repeat (n) @(negedge clk);
    endtask

    // let the queue drain, then write a new expiry limit
    task automatic set_expiry(input logic [TIME_W-1:0] limit);
        while (expected_results.size() != 0) @(negedge clk);
        repeat (WALK_CYCLES) @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_wdata <= limit;
        @(negedge clk);
        cfg_we <= 1'b0;
        max_age = limit;
        n_settings++;
    endtask

    // result checker
    always @(posedge clk) begin
        t_result want;
        if (rst_n && out_if.valid === 1'b1 && out_if.ready === 1'b1) begin
            if (expected_results.size() == 0) begin
                $error("unexpected result transfer, status %0d", out_if.status);
                errors++;
            end else begin
                want = expected_results.pop_front();
                if (out_if.status !== want.status) begin
                    $error("status: expected %0d, got %0d", want.status, out_if.status);
                    errors++;
                end
                if (out_if.out_type !== want.out_type) begin
                    $error("out_type: expected %0d, got %0d", want.out_type, out_if.out_type);
                    errors++;
                end
                if (out_if.out_payload !== want.out_payload) begin
                    $error("out_payload: expected %h, got %h", want.out_payload,
                           out_if.out_payload);
                    errors++;
                end
                if (out_if.out_payload_ext !== want.out_payload_ext) begin
                    $error("out_payload_ext: expected %h, got %h", want.out_payload_ext,
                           out_if.out_payload_ext);
                    errors++;
                end
                if (out_if.expired_count !== want.expired_count) begin
                    $error("expired_count: expected %0d, got %0d", want.expired_count,
                           out_if.expired_count);
                    errors++;
                end
                if (out_if.occupancy !== want.occupancy) begin
                    $error("occupancy: expected %0d, got %0d", want.occupancy,
                           out_if.occupancy);
                    errors++;
                end
                case (out_if.status)
                    ST_DELIVERED: n_delivered++;
                    ST_COALESCED: n_coalesced++;
                    ST_DROPPED:   n_dropped++;
                    default: ;
                endcase
                n_expired += int'(out_if.expired_count);
            end
        end
    end

    // receiver: open, random, or mostly stalled, in randomly chosen modes
    initial begin
        int mode;
        int left;
        int tick;
        mode = 0;
        left = 0;
        tick = 0;
        out_if.ready = 1'b0;
        forever begin
            @(negedge clk);
            if (left == 0) begin
                mode = $urandom_range(0, 2);
                left = $urandom_range(32, 200);
            end
            left--;
            tick++;
            case (mode)
                0: out_if.ready <= 1'b1;
                1: out_if.ready <= 1'($urandom_range(0, 1));
                default: out_if.ready <= ((tick % 11) < 3);
            endcase
        end
    end

    // stimulus
    initial begin
        t_row             dir_rows[$];
        t_row             row;
        t_in_item         cmd;
        logic [TIME_W-1:0] limits[PHASES];
        int               burst_left;
        int               enq_pct;

        errors = 0;
        n_enq = 0; n_poll = 0; n_settings = 0;
        n_delivered = 0; n_coalesced = 0; n_dropped = 0; n_expired = 0;
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_wdata = '0;
        in_if.valid = 1'b0;
        in_if.action = ACT_ENQUEUE;
        in_if.cmd_type = '0;
        in_if.payload = '0;
        in_if.payload_ext = '0;
        in_if.now_ms = '0;

        // shadow state after reset
        head_ptr = '0;
        tail_ptr = '0;
        fill = 0;
        max_age = EXPIRY_RESET;
        clock_ms = '0;
        foreach (slot_q[i]) slot_q[i] = '0;

        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // directed: fill past full, coalesce, drop, expire at the limit edge, wrap time
        dir_rows.push_back(mk_row(ACT_POLL, 0, '0, 0, 0, 1, ST_EMPTY, 0, '0, 0, 0, 0));
        dir_rows.push_back(mk_row(ACT_ENQUEUE, 0, PAY_ONES, 255, 0, 1,
                                  ST_APPENDED, 0, '0, 0, 0, 1));
        dir_rows.push_back(mk_row(ACT_ENQUEUE, 0, '0, 0, 5, 1,
                                  ST_COALESCED, 0, '0, 0, 0, 1));
        dir_rows.push_back(mk_row(ACT_ENQUEUE, 4, 64'h0123_4567_89AB_CDEF, 8'h5A, 5, 1,
                                  ST_APPENDED, 0, '0, 0, 0, 2));
        dir_rows.push_back(mk_row(ACT_ENQUEUE, 4, 64'hAAAA_AAAA_AAAA_AAAA, 8'hA5, 6, 1,
                                  ST_APPENDED, 0, '0, 0, 0, 3));
        // type beyond toggle never coalesces
        dir_rows.push_back(mk_row(ACT_ENQUEUE, 7, 64'h5555_5555_5555_5555, 8'h3C, 7, 1,
                                  ST_APPENDED, 0, '0, 0, 0, 4));
        dir_rows.push_back(mk_row(ACT_ENQUEUE, 1, 64'h0F0F_0F0F_F0F0_F0F0, 8'h0F, 8, 0,
                                  ST_APPENDED, 0, '0, 0, 0, 0));
        dir_rows.push_back(mk_row(ACT_ENQUEUE, 2, 64'h8000_0000_0000_0001, 8'h80, 9, 0,
                                  ST_APPENDED, 0, '0, 0, 0, 0));
        dir_rows.push_back(mk_row(ACT_ENQUEUE, 3, 64'h7FFF_FFFF_FFFF_FFFE, 8'hFF, 10, 0,
                                  ST_APPENDED, 0, '0, 0, 0, 0));
        dir_rows.push_back(mk_row(ACT_ENQUEUE, 5, 64'hDEAD_0000_BEEF_0000, 8'h01, 11, 1,
                                  ST_APPENDED, 0, '0, 0, 0, 8));
        dir_rows.push_back(mk_row(ACT_ENQUEUE, 6, PAY_ONES, 255, 12, 1,
                                  ST_DROPPED, 0, '0, 0, 0, 8));
        dir_rows.push_back(mk_row(ACT_ENQUEUE, 4, '0, 0, 12, 1,
                                  ST_DROPPED, 0, '0, 0, 0, 8));
        // coalescing still works on a full queue
        dir_rows.push_back(mk_row(ACT_ENQUEUE, 1, 64'h1111, 8'h11, 20, 1,
                                  ST_COALESCED, 0, '0, 0, 0, 8));
        // age equal to the limit is still live
        dir_rows.push_back(mk_row(ACT_POLL, 0, '0, 0, 10005, 1,
                                  ST_DELIVERED, 0, '0, 0, 0, 7));
        dir_rows.push_back(mk_row(ACT_POLL, 0, '0, 0, 10006, 1,
                                  ST_DELIVERED, 4, 64'hAAAA_AAAA_AAAA_AAAA, 8'hA5, 1, 5));
        dir_rows.push_back(mk_row(ACT_POLL, 0, '0, 0, 10008, 1,
                                  ST_DELIVERED, 1, 64'h1111, 8'h11, 1, 3));
        dir_rows.push_back(mk_row(ACT_POLL, 7, PAY_ONES, 255, 32'hFFFF_FFFF, 1,
                                  ST_EMPTY, 0, '0, 0, 3, 0));
        // time stamps across the 32-bit wrap
        dir_rows.push_back(mk_row(ACT_ENQUEUE, 2, 64'hCAFE, 8'h42, 32'hFFFF_FFF0, 0,
                                  ST_APPENDED, 0, '0, 0, 0, 0));
        dir_rows.push_back(mk_row(ACT_ENQUEUE, 2, 64'hF00D, 8'h24, 32'hFFFF_FFF8, 0,
                                  ST_APPENDED, 0, '0, 0, 0, 0));
        dir_rows.push_back(mk_row(ACT_POLL, 0, '0, 0, 32'h0000_0010, 0,
                                  ST_APPENDED, 0, '0, 0, 0, 0));
        dir_rows.push_back(mk_row(ACT_ENQUEUE, 3, 64'h1234, 8'h56, 100, 0,
                                  ST_APPENDED, 0, '0, 0, 0, 0));
        dir_rows.push_back(mk_row(ACT_POLL, 0, '0, 0, 100 + 10001, 0,
                                  ST_APPENDED, 0, '0, 0, 0, 0));

        foreach (dir_rows[i]) begin
            row = dir_rows[i];
            send_cmd(row.cmd, row.typed, row.want);
            if ($urandom_range(0, 2) == 0) pause($urandom_range(1, 4));
        end
        pause(1);

        // random phases, each under its own expiry limit
        limits[0] = '0;
        limits[1] = {TIME_W{1'b1}};
        limits[2] = TIME_W'(1);
        limits[3] = TIME_W'($urandom_range(50, 5000));
        limits[4] = $urandom;
        limits[5] = EXPIRY_RESET;
        for (int p = 0; p < PHASES; p++) begin
            set_expiry(limits[p]);
            burst_left = $urandom_range(1, 24);
            enq_pct = 65;
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                if (n % 32 == 0) begin
                    case ($urandom_range(0, 2))
                        0: enq_pct = 40;
                        1: enq_pct = 65;
                        default: enq_pct = 90;
                    endcase
                end
                cmd = make_random_item(enq_pct);
                send_cmd(cmd, 1'b0, '0);
                if (burst_left == 0) begin
                    burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(40, 80)
                                                             : $urandom_range(1, 24);
                    pause($urandom_range(1, 8));
                end else begin
                    burst_left--;
                end
            end
            pause(1);
        end

        // drain and settle
        while (expected_results.size() != 0) @(negedge clk);
        repeat (WALK_CYCLES + 5) @(negedge clk);

        $display("Ran %0d enqueues and %0d polls under %0d expiry settings after reset.",
                 n_enq, n_poll, n_settings);
        $display("Seen %0d deliveries, %0d coalesced, %0d dropped, %0d entries expired.",
                 n_delivered, n_coalesced, n_dropped, n_expired);
        if (errors == 0) begin
            $display("testbench passed");
        end else begin
            $display("testbench failed");
        end
        $finish;
    end

endmodule
